// File: hdl/utfs_pkg.sv
// Shared types and constants of the UTF-8 sanitizer stream unit.
package utfs_pkg;

    // Replacement counter width and reported total width
    localparam int CountWidth = 32;
    localparam int TotalWidth = 32;

    // Result queue geometry
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    // Most results one input byte can cause
    localparam int MaxResults = 4;

    // Byte classes
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] CtrlLimit = 8'h20;
    localparam logic [7:0] DelChar   = 8'h7F;
    localparam logic [7:0] C1Top     = 8'h9F;
    localparam logic [7:0] Lead2Lo   = 8'hC2;
    localparam logic [7:0] Lead2Hi   = 8'hDF;
    localparam logic [7:0] Lead3Lo   = 8'hE0;
    localparam logic [7:0] Lead3Hi   = 8'hEF;
    localparam logic [7:0] Lead3Sur  = 8'hED;
    localparam logic [7:0] Lead4Lo   = 8'hF0;
    localparam logic [7:0] Lead4Hi   = 8'hF4;
    localparam logic [7:0] Cont3Min  = 8'hA0;
    localparam logic [7:0] Cont4Min  = 8'h90;
    localparam logic [7:0] Cont4Max  = 8'h8F;
    localparam logic [7:0] QMark     = 8'h3F;

    // One result item before counting
    typedef struct packed {
        logic [7:0] byte_val;
        logic       sub;
        logic       is_end;
    } t_res;

    // All results caused by one input byte
    typedef struct packed {
        logic [$clog2(MaxResults+1)-1:0] num;
        t_res [MaxResults-1:0]           item;
    } t_group;

endpackage

// File: hdl/utfs_front.sv
// Front end: decodes input bytes and builds the result group of each byte.
module utfs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte_in,
    input  logic            i_last_byte,
    input  logic            i_fifo_full,
    output logic            o_push,
    output utfs_pkg::t_group o_group
);
    import utfs_pkg::*;

    localparam int NumW = $clog2(MaxResults+1);

    logic [23:0]     r_held;
    logic [23:0]     n_held;
    logic [1:0]      r_hcnt;
    logic [1:0]      n_hcnt;
    logic            r_skip;
    logic            n_skip;
    logic            accept;
    t_group          grp;

    assign accept  = i_valid && !i_fifo_full;
    assign o_stall = i_fifo_full;
    assign o_push  = accept && (grp.num != '0);
    assign o_group = grp;

    // Classify the byte against the held sequence and list its results
    always_comb begin
        logic            cont;
        logic [7:0]      lead;
        logic [7:0]      b;
        logic            do_fresh;
        logic            ok;
        logic [NumW-1:0] idx;
        n_held   = r_held;
        n_hcnt   = r_hcnt;
        n_skip   = r_skip;
        grp      = '0;
        b        = i_byte_in;
        cont     = (b & ContMask) == ContTag;
        lead     = r_held[7:0];
        do_fresh = 1'b0;
        ok       = 1'b0;
        idx      = '0;

        if (r_skip) begin
            if (!cont) begin
                n_skip   = 1'b0;
                do_fresh = 1'b1;
            end
        end else if (r_hcnt == 2'd0) begin
            do_fresh = 1'b1;
        end else if (lead <= Lead2Hi) begin
            // two-byte sequence completes or breaks
            if (cont) begin
                if (lead == Lead2Lo && b <= C1Top) begin
                    grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                    idx = idx + 1'b1;
                end else begin
                    grp.item[idx[1:0]] = '{lead, 1'b0, 1'b0};
                    idx = idx + 1'b1;
                    grp.item[idx[1:0]] = '{b, 1'b0, 1'b0};
                    idx = idx + 1'b1;
                end
            end else begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx = idx + 1'b1;
                do_fresh = 1'b1;
            end
            n_held = '0;
            n_hcnt = 2'd0;
        end else if (lead <= Lead3Hi) begin
            // three-byte sequence
            if (r_hcnt == 2'd1) begin
                ok = cont && !(lead == Lead3Lo && b < Cont3Min)
                          && !(lead == Lead3Sur && b > C1Top);
                if (ok) begin
                    n_held[15:8] = b;
                    n_hcnt       = 2'd2;
                end else begin
                    grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                    idx    = idx + 1'b1;
                    n_held = '0;
                    n_hcnt = 2'd0;
                    if (cont) n_skip = 1'b1;
                    else      do_fresh = 1'b1;
                end
            end else if (cont) begin
                grp.item[idx[1:0]] = '{lead, 1'b0, 1'b0};
                idx = idx + 1'b1;
                grp.item[idx[1:0]] = '{r_held[15:8], 1'b0, 1'b0};
                idx = idx + 1'b1;
                grp.item[idx[1:0]] = '{b, 1'b0, 1'b0};
                idx = idx + 1'b1;
                n_held = '0;
                n_hcnt = 2'd0;
            end else begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx      = idx + 1'b1;
                n_held   = '0;
                n_hcnt   = 2'd0;
                do_fresh = 1'b1;
            end
        end else begin
            // four-byte sequence, replaced as a whole
            if (r_hcnt == 2'd1) begin
                ok = cont && !(lead == Lead4Lo && b < Cont4Min)
                          && !(lead == Lead4Hi && b > Cont4Max);
                if (ok) begin
                    n_held[15:8] = b;
                    n_hcnt       = 2'd2;
                end else begin
                    grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                    idx    = idx + 1'b1;
                    n_held = '0;
                    n_hcnt = 2'd0;
                    if (cont) n_skip = 1'b1;
                    else      do_fresh = 1'b1;
                end
            end else if (!cont) begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx      = idx + 1'b1;
                n_held   = '0;
                n_hcnt   = 2'd0;
                do_fresh = 1'b1;
            end else if (r_hcnt == 2'd2) begin
                n_held[23:16] = b;
                n_hcnt        = 2'd3;
            end else begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx    = idx + 1'b1;
                n_held = '0;
                n_hcnt = 2'd0;
            end
        end

        // Treat the byte as the start of something new
        if (do_fresh) begin
            if (b < ContTag) begin
                if (b < CtrlLimit || b == DelChar) begin
                    grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                end else begin
                    grp.item[idx[1:0]] = '{b, 1'b0, 1'b0};
                end
                idx = idx + 1'b1;
            end else if ((b >= Lead2Lo && b <= Lead2Hi) || (b >= Lead3Lo && b <= Lead3Hi) ||
                         (b >= Lead4Lo && b <= Lead4Hi)) begin
                n_held = {16'h0000, b};
                n_hcnt = 2'd1;
            end else begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx    = idx + 1'b1;
                n_skip = 1'b1;
            end
        end

        // Close the text: flush a truncated sequence, then the end item
        if (i_last_byte) begin
            if (n_hcnt != 2'd0) begin
                grp.item[idx[1:0]] = '{QMark, 1'b1, 1'b0};
                idx = idx + 1'b1;
            end
            n_held = '0;
            n_hcnt = 2'd0;
            n_skip = 1'b0;
            grp.item[idx[1:0]] = '{8'h00, 1'b0, 1'b1};
            idx = idx + 1'b1;
        end

        grp.num = idx;
    end

    // Advance decoder state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_hcnt <= 2'd0;
            r_skip <= 1'b0;
        end else if (accept) begin
            r_held <= n_held;
            r_hcnt <= n_hcnt;
            r_skip <= n_skip;
        end
    end

endmodule

// File: hdl/utfs_fifo.sv
// Short queue of result groups between the front and back ends.
module utfs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utfs_pkg::t_group i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output utfs_pkg::t_group o_head
);
    import utfs_pkg::*;

    t_group          r_mem [FifoDepth];
    logic [FifoAw:0] r_wr;
    logic [FifoAw:0] r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[FifoAw-1:0] == r_rd[FifoAw-1:0]) && (r_wr[FifoAw] != r_rd[FifoAw]);
    assign o_head  = r_mem[r_rd[FifoAw-1:0]];

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[FifoAw-1:0]] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
        end
    end

endmodule

// File: hdl/utfs_back.sv
// Back end: serializes result groups, counts replacements, holds the output register.
module utfs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  utfs_pkg::t_group            i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_byte_out,
    output logic                        o_substituted,
    output logic                        o_end_item,
    output logic [utfs_pkg::TotalWidth-1:0] o_replacement_total,
    output logic                        o_run_last
);
    import utfs_pkg::*;

    localparam int NumW = $clog2(MaxResults+1);
    localparam int IdxW = $clog2(MaxResults);

    logic [IdxW-1:0]       r_idx;
    logic [CountWidth-1:0] r_count;
    logic [CountWidth-1:0] n_count;
    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_sub;
    logic                  r_end;
    logic [TotalWidth-1:0] r_total;
    logic [TotalWidth-1:0] n_total;
    logic                  r_last;
    logic                  advance;
    logic                  is_last;
    t_res                  cur;
    logic [63:0]           count_ext;

    assign advance = !i_empty && (!r_valid || !i_stall);
    assign cur     = i_head.item[r_idx];
    assign is_last = (NumW'(r_idx) + 1'b1) == i_head.num;
    assign o_pop   = advance && is_last;

    // Saturating count including this result
    always_comb begin
        n_count = r_count;
        if (cur.sub && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
        count_ext = 64'(n_count);
        if (|count_ext[63:TotalWidth]) begin
            n_total = '1;
        end else begin
            n_total = count_ext[TotalWidth-1:0];
        end
    end

    // Walk the group and keep the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_idx   <= is_last ? '0 : r_idx + 1'b1;
            r_count <= cur.is_end ? '0 : n_count;
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte  <= cur.byte_val;
            r_sub   <= cur.sub;
            r_end   <= cur.is_end;
            r_total <= n_total;
            r_last  <= is_last;
        end
    end

    assign o_valid             = r_valid;
    assign o_byte_out          = r_byte;
    assign o_substituted       = r_sub;
    assign o_end_item          = r_end;
    assign o_replacement_total = r_total;
    assign o_run_last          = r_last;

endmodule

// File: hdl/utf8_sanitizer_stream_unit.sv
// Top level of the UTF-8 sanitizer stream unit.
// Input channel: one raw text byte per transfer (i_byte_in, i_last_byte), i_valid with
// o_stall. Output channel: one sanitized byte or the closing end item per transfer,
// o_valid with i_stall, each carrying the running replacement total.
// The front end decodes a byte in the cycle it is taken and pushes the results it
// causes (one to four; a byte with none pushes nothing) as one group into a four-entry
// queue; the back end sends them out one per cycle while the output is not stalled,
// from a registered output stage. The results of a byte pass through the queue and
// then through the output register on their way out.
// Throughput: one byte per cycle while each byte causes at most one result and the
// output is not stalled; a byte that causes several results holds the output for one
// transfer per result, and the queue absorbs such bursts. o_stall rises only when
// the queue is full. A stalled output holds its result; the back end keeps walking
// only when the output register is free, so results are neither lost nor repeated.
// After the end item the decoder state and the replacement count restart at zero.
// Reset (synchronous, active low) empties the queue and clears all decoder state; the
// block can accept bytes as soon as reset is released.
module utf8_sanitizer_stream_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_byte_in,
    input  logic                            i_last_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_byte_out,
    output logic                            o_substituted,
    output logic                            o_end_item,
    output logic [utfs_pkg::TotalWidth-1:0] o_replacement_total,
    output logic                            o_run_last
);
    import utfs_pkg::*;

    logic   fifo_full;
    logic   fifo_empty;
    logic   push;
    logic   pop;
    t_group push_grp;
    t_group head_grp;

    utfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_group     (push_grp)
    );

    utfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_grp),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (head_grp)
    );

    utfs_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (fifo_empty),
        .i_head              (head_grp),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_byte_out          (o_byte_out),
        .o_substituted       (o_substituted),
        .o_end_item          (o_end_item),
        .o_replacement_total (o_replacement_total),
        .o_run_last          (o_run_last)
    );

endmodule

// File: test/utf8_sanitizer_stream_unit_test.sv
// Self-checking testbench for the UTF-8 sanitizer stream unit.
module utf8_sanitizer_stream_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utfs_pkg::*;

    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 8;
    localparam int HoldOffLen  = 64;
    localparam int RandomBytes = 180;

    // Kinds of character the random text generator builds
    typedef enum int {
        SEQ_ASCII,
        SEQ_TWO,
        SEQ_THREE,
        SEQ_FOUR,
        SEQ_BROKEN,
        SEQ_NOISE
    } t_seq_kind;

    // One sanitized output transfer as predicted
    typedef struct {
        logic [7:0]            byte_val;
        logic                  sub;
        logic                  is_end;
        logic [TotalWidth-1:0] total;
        logic                  run_last;
    } t_sanitized;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_byte_in;
    logic                  i_last_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_byte_out;
    logic                  o_substituted;
    logic                  o_end_item;
    logic [TotalWidth-1:0] o_replacement_total;
    logic                  o_run_last;

    // Decoder state mirrored from the block
    logic [23:0]           held_seq    = '0;
    logic [1:0]            held_len    = '0;
    logic                  skip_cont   = 1'b0;
    logic [CountWidth-1:0] repl_count  = '0;
    logic                  byte_ignored;

    t_sanitized sanitized_q[$];
    t_sanitized step_out[$];

    // Run control and bookkeeping
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_off_req = 1'b0;
    int mismatches   = 0;
    int bytes_counted = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int subs_seen    = 0;
    int texts_seen   = 0;
    int stall_cycles = 0;
    int idle_cycles  = 0;

    utf8_sanitizer_stream_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_byte_in           (i_byte_in),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_byte_out          (o_byte_out),
        .o_substituted       (o_substituted),
        .o_end_item          (o_end_item),
        .o_replacement_total (o_replacement_total),
        .o_run_last          (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Sanitizer prediction
    // ---------------------------------------------------------------

    // Append one result; replacements bump the saturating count first
    function automatic void put_result(logic [7:0] b, logic sub, logic is_end);
        t_sanitized r;
        if (sub && repl_count != '1) repl_count = repl_count + 1'b1;
        r.byte_val = b;
        r.sub      = sub;
        r.is_end   = is_end;
        r.total    = (64'(repl_count) > 64'({TotalWidth{1'b1}})) ? '1
                                                                  : TotalWidth'(repl_count);
        r.run_last = 1'b0;
        step_out = {step_out, r};
    endfunction

    function automatic void clear_seq();
        held_seq = '0;
        held_len = '0;
    endfunction

    // Treat a byte as the start of a new character
    function automatic void start_fresh(logic [7:0] b);
        if (b < ContTag) begin
            if (b < CtrlLimit || b == DelChar) put_result(QMark, 1'b1, 1'b0);
            else put_result(b, 1'b0, 1'b0);
        end else if (b >= Lead2Lo && b <= Lead4Hi) begin
            held_seq = {16'h0, b};
            held_len = 2'd1;
        end else begin
            put_result(QMark, 1'b1, 1'b0);
            skip_cont = 1'b1;
        end
    endfunction

    // Drop the held sequence; a continuation starts skipping, anything else restarts
    function automatic void break_seq(logic cont, logic [7:0] b);
        put_result(QMark, 1'b1, 1'b0);
        clear_seq();
        if (cont) skip_cont = 1'b1;
        else start_fresh(b);
    endfunction

    function automatic void hold_byte(logic [7:0] b);
        held_seq = held_seq | (24'(b) << (8 * held_len));
        held_len = held_len + 2'd1;
    endfunction

    // Work out every result one accepted byte causes and queue them
    function automatic void sanitize_byte(logic [7:0] b, logic is_last);
        logic       cont;
        logic [7:0] lead;
        t_sanitized r;
        cont = (b & ContMask) == ContTag;
        lead = held_seq[7:0];
        step_out = {};
        byte_ignored = 1'b0;

        if (skip_cont) begin
            if (!cont) begin
                skip_cont = 1'b0;
                start_fresh(b);
            end else begin
                byte_ignored = !is_last;
            end
        end else if (held_len == 0) begin
            start_fresh(b);
        end else if (lead <= Lead2Hi) begin
            if (cont) begin
                if (lead == Lead2Lo && b <= C1Top) begin
                    put_result(QMark, 1'b1, 1'b0);
                end else begin
                    put_result(lead, 1'b0, 1'b0);
                    put_result(b, 1'b0, 1'b0);
                end
                clear_seq();
            end else begin
                break_seq(1'b0, b);
            end
        end else if (lead <= Lead3Hi) begin
            if (held_len == 1) begin
                if (cont && !(lead == Lead3Lo && b < Cont3Min)
                         && !(lead == Lead3Sur && b > C1Top)) hold_byte(b);
                else break_seq(cont, b);
            end else if (cont) begin
                put_result(lead, 1'b0, 1'b0);
                put_result(held_seq[15:8], 1'b0, 1'b0);
                put_result(b, 1'b0, 1'b0);
                clear_seq();
            end else begin
                break_seq(1'b0, b);
            end
        end else begin
            if (held_len == 1) begin
                if (cont && !(lead == Lead4Lo && b < Cont4Min)
                         && !(lead == Lead4Hi && b > Cont4Max)) hold_byte(b);
                else break_seq(cont, b);
            end else if (!cont) begin
                break_seq(1'b0, b);
            end else if (held_len == 2) begin
                hold_byte(b);
            end else begin
                // complete four-byte character collapses to one replacement
                put_result(QMark, 1'b1, 1'b0);
                clear_seq();
            end
        end

        // Close the text: flush a truncated sequence, then the end item
        if (is_last) begin
            if (held_len != 0) put_result(QMark, 1'b1, 1'b0);
            clear_seq();
            skip_cont = 1'b0;
            put_result(8'h00, 1'b0, 1'b1);
            repl_count = '0;
        end

        foreach (step_out[i]) begin
            r = step_out[i];
            r.run_last = (i == step_out.size() - 1);
            sanitized_q = {sanitized_q, r};
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap = 0;
        if (src_idle_on) begin
            if (pick >= 92) gap = $urandom_range(8, 30);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_byte_in   = b;
        i_last_byte = is_last;
        do @(posedge i_clk); while (o_stall);
        sanitize_byte(b, is_last);
        bytes_sent++;
        if (!byte_ignored) bytes_counted++;
    endtask

    // Build one character, mostly well formed, and send its bytes
    task automatic send_random_char();
        logic [7:0] seq[$];
        logic [7:0] lead;
        t_seq_kind  kind;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      kind = SEQ_ASCII;
        else if (pick < 45) kind = SEQ_TWO;
        else if (pick < 65) kind = SEQ_THREE;
        else if (pick < 78) kind = SEQ_FOUR;
        else if (pick < 90) kind = SEQ_BROKEN;
        else                kind = SEQ_NOISE;

        case (kind)
            SEQ_ASCII: begin
                seq = {seq, 8'($urandom_range(0, 127))};
            end
            SEQ_TWO: begin
                seq = {seq, 8'($urandom_range(Lead2Lo, Lead2Hi))};
                seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
            end
            SEQ_THREE: begin
                lead = 8'($urandom_range(Lead3Lo, Lead3Hi));
                seq = {seq, lead};
                seq = {seq, 8'($urandom_range(lead == Lead3Lo ? Cont3Min : 8'h80,
                                              lead == Lead3Sur ? C1Top : 8'hBF))};
                seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
            end
            SEQ_FOUR: begin
                lead = 8'($urandom_range(Lead4Lo, Lead4Hi));
                seq = {seq, lead};
                seq = {seq, 8'($urandom_range(lead == Lead4Lo ? Cont4Min : 8'h80,
                                              lead == Lead4Hi ? Cont4Max : 8'hBF))};
                seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
                seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
            end
            SEQ_BROKEN: begin
                // lead byte, possibly a good continuation, then anything at all
                seq = {seq, 8'($urandom_range(Lead2Lo, Lead4Hi))};
                if ($urandom_range(0, 1)) seq = {seq, 8'($urandom_range(8'h80, 8'hBF))};
                seq = {seq, 8'($urandom_range(0, 255))};
            end
            default: begin
                repeat ($urandom_range(1, 3)) seq = {seq, 8'($urandom_range(0, 255))};
            end
        endcase

        foreach (seq[i]) send_byte(seq[i], $urandom_range(0, 24) == 0);
    endtask

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------

    // Stall the output at random; a hold-off request overrides for a long stretch
    initial begin : sink_stall
        int run_left;
        int hold_left;
        run_left  = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_left    = HoldOffLen;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (run_left > 0) begin
                run_left--;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                i_stall  = 1'b1;
                run_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                        : $urandom_range(10, 30);
            end else begin
                i_stall  = 1'b0;
                run_left = sink_idle_on ? $urandom_range(0, 6) : 0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_sanitized want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_substituted) subs_seen++;
            if (o_end_item) texts_seen++;
            if (sanitized_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got byte %02h end %0b",
                         $time, o_byte_out, o_end_item);
            end else begin
                want = sanitized_q.pop_front();
                check_field("byte_out", 32'(want.byte_val), 32'(o_byte_out));
                check_field("substituted", 32'(want.sub), 32'(o_substituted));
                check_field("end_item", 32'(want.is_end), 32'(o_end_item));
                check_field("replacement_total", 32'(want.total), 32'(o_replacement_total));
                check_field("run_last", 32'(want.run_last), 32'(o_run_last));
            end
        end
    end

    // Count idle cycles with no transfer on either side and stop a hung run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) stall_cycles++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sanitized_q.size());
                $display("FAIL utf8_sanitizer_stream_unit");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-picked bytes covering the byte classes and several ways a sequence goes wrong
    task automatic test_directed_cases();
        logic [7:0] text_a[$];
        text_a = '{8'h20, 8'h00, 8'h7F,       // space, NUL and DEL
                   8'hC2, 8'h85,              // two-byte C1 control
                   8'hDF, 8'hBF,              // top two-byte character
                   8'hE0, 8'h80, 8'hBF,       // overlong form, tail swallowed
                   8'hED, 8'hA0,              // surrogate
                   8'hE2, 8'h82, 8'hAC,       // euro sign
                   8'hF4, 8'h8F, 8'h80, 8'h80, // four-byte character
                   8'hFF,                     // byte that is never valid
                   8'hC3, 8'h7E,              // broken by ASCII, which still passes
                   8'hF0, 8'h90};             // truncated by end of text
        foreach (text_a[i]) send_byte(text_a[i], i == text_a.size() - 1);
        send_byte(8'h41, 1'b1);
    endtask

    // Random texts with idling on both sides
    task automatic test_random_text();
        int target;
        target = bytes_counted + RandomBytes;
        while (bytes_counted < target) send_random_char();
        send_byte(8'h2E, 1'b1);
    endtask

    // Full-rate stretch: no gaps from the sender, and the receiver starts no new stalls
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (30) send_random_char();
        send_byte(8'h0A, 1'b1);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Hold off the receiver while bytes keep coming so the input stalls
    task automatic test_output_hold_off();
        src_idle_on  = 1'b0;
        hold_off_req = 1'b1;
        repeat (20) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        send_byte(8'h7A, 1'b1);
        src_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_byte_in   = '0;
        i_last_byte = 1'b0;
        i_stall     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_text();
        test_back_to_back();
        test_output_hold_off();

        // Drain: drop valid, wait for every prediction, then a few quiet cycles
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sanitized_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts; checked %0d results, %0d of them replacements.",
                 bytes_sent, texts_seen, results_seen, subs_seen);
        $display("Input was held off for %0d cycles; %0d field mismatches.",
                 stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("PASS utf8_sanitizer_stream_unit");
        end else begin
            $display("FAIL utf8_sanitizer_stream_unit");
        end
        $finish;
    end

endmodule
